/* design/plf_pkg.sv */
// Shared constants and controller/datapath interface types for the PWM fade controller.
// Self-contained: this package depends on nothing else.
package plf_pkg;

    // Duty resolution and the fixed widths of the transaction fields.
    localparam int DUTY_BITS    = 8;
    localparam int DUTY_MAX     = (1 << DUTY_BITS) - 1;
    localparam int TIME_BITS    = 16;
    localparam int PCT_BITS     = 8;
    localparam int PCT_C_BITS   = 7;
    localparam int PERCENT_FULL = 100;

    // Opcode of the operation field.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Percent to duty scaling: (pct * DUTY_MAX) / 100 via a reciprocal multiply.
    localparam int SCALED_BITS     = PCT_C_BITS + DUTY_BITS;
    localparam int RECIP_SHIFT     = 24;
    localparam int RECIP_BITS      = 18;
    localparam int RECIP_MUL       = ((1 << RECIP_SHIFT) + PERCENT_FULL - 1) / PERCENT_FULL;
    localparam int RECIP_PROD_BITS = SCALED_BITS + RECIP_BITS;

    // Line-point division: numerator is span * elapsed, plus a rounding term on a downward fade.
    localparam int NUM_BITS = DUTY_BITS + TIME_BITS;
    localparam int CNT_BITS = (DUTY_BITS > 1) ? $clog2(DUTY_BITS) : 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic scale;
        logic recip;
        logic apply_set;
        logic tick_inc;
        logic tick_end;
        logic mult;
        logic div_init;
        logic div_step;
        logic div_end;
        logic load_out;
    } t_plf_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fading;
        logic fade_end;
    } t_plf_status;

endpackage

/* design/plf_dpath.sv */
// Datapath of the PWM fade controller: fade state, scaling multipliers and serial divider.
// Depends on plf_pkg for widths, constants and the command/status structs.
module plf_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  plf_pkg::t_plf_cmd              i_cmd,
    output plf_pkg::t_plf_status           o_sts,
    input  logic                           i_operation,
    input  logic [plf_pkg::PCT_BITS-1:0]   i_target_percent,
    input  logic [plf_pkg::TIME_BITS-1:0]  i_fade_time_ms,
    output logic [7:0]                     o_duty_out,
    output logic                           o_fade_active
);

    // Architectural fade state.
    logic [plf_pkg::DUTY_BITS-1:0]       r_cur, r_start, r_target;
    logic [plf_pkg::TIME_BITS-1:0]       r_len, r_elapsed;
    logic                                r_fading;

    // Working registers for one transaction.
    logic [plf_pkg::PCT_C_BITS-1:0]      r_pct;
    logic [plf_pkg::TIME_BITS-1:0]       r_ftime;
    logic [plf_pkg::SCALED_BITS-1:0]     r_scaled;
    logic [plf_pkg::DUTY_BITS-1:0]       r_new_duty;
    logic [plf_pkg::NUM_BITS-1:0]        r_prod;
    logic [plf_pkg::DUTY_BITS-1:0]       r_span;
    logic                                r_down;
    logic [plf_pkg::TIME_BITS-1:0]       r_rem;
    logic [plf_pkg::DUTY_BITS-1:0]       r_shift;
    logic [plf_pkg::DUTY_BITS-1:0]       r_out_duty;
    logic                                r_out_fade;

    logic [plf_pkg::PCT_C_BITS-1:0]      n_pct;
    logic [plf_pkg::SCALED_BITS-1:0]     n_scaled;
    logic [plf_pkg::RECIP_PROD_BITS-1:0] n_recip;
    logic                                n_down;
    logic [plf_pkg::DUTY_BITS-1:0]       n_span;
    logic [plf_pkg::NUM_BITS-1:0]        n_prod;
    logic [plf_pkg::NUM_BITS-1:0]        n_num;
    logic [plf_pkg::TIME_BITS:0]         n_trial;
    logic                                n_ge;
    logic [plf_pkg::TIME_BITS-1:0]       n_rem;
    logic [plf_pkg::DUTY_BITS-1:0]       n_shift;
    logic [plf_pkg::DUTY_BITS-1:0]       n_q;
    logic [plf_pkg::DUTY_BITS-1:0]       n_point;

    // Percent clamp and the two scaling products.
    always_comb begin
        if (i_target_percent > plf_pkg::PCT_BITS'(plf_pkg::PERCENT_FULL)) begin
            n_pct = plf_pkg::PCT_C_BITS'(plf_pkg::PERCENT_FULL);
        end else begin
            n_pct = i_target_percent[plf_pkg::PCT_C_BITS-1:0];
        end
        n_scaled = plf_pkg::SCALED_BITS'(r_pct) * plf_pkg::SCALED_BITS'(plf_pkg::DUTY_MAX);
        n_recip  = plf_pkg::RECIP_PROD_BITS'(r_scaled)
                 * plf_pkg::RECIP_PROD_BITS'(plf_pkg::RECIP_MUL);
    end

    // Span of the fade and the span-times-elapsed product.
    always_comb begin
        n_down = (r_target < r_start);
        n_span = n_down ? (r_start - r_target) : (r_target - r_start);
        n_prod = plf_pkg::NUM_BITS'(n_span) * plf_pkg::NUM_BITS'(r_elapsed);
    end

    // Division numerator; a downward fade rounds the step magnitude up.
    always_comb begin
        if (r_down) begin
            n_num = r_prod + plf_pkg::NUM_BITS'(r_len) - plf_pkg::NUM_BITS'(1);
        end else begin
            n_num = r_prod;
        end
    end

    // One restoring division step; quotient bits shift in behind the numerator bits.
    always_comb begin
        n_trial = {r_rem, r_shift[plf_pkg::DUTY_BITS-1]};
        n_ge    = (n_trial >= {1'b0, r_len});
        if (n_ge) begin
            n_rem = plf_pkg::TIME_BITS'(n_trial - {1'b0, r_len});
        end else begin
            n_rem = n_trial[plf_pkg::TIME_BITS-1:0];
        end
        n_shift = (r_shift << 1) | plf_pkg::DUTY_BITS'(n_ge);
    end

    // New point on the line once the quotient is complete.
    always_comb begin
        n_q = r_shift;
        if (r_down) begin
            if (n_q > r_start) begin
                n_q = r_start;
            end
            n_point = r_start - n_q;
        end else begin
            n_point = r_start + n_q;
        end
    end

    // Fade state, which reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_start   <= '0;
            r_target  <= '0;
            r_len     <= '0;
            r_elapsed <= '0;
            r_fading  <= 1'b0;
        end else begin
            if (i_cmd.apply_set && (r_new_duty != r_cur)) begin
                r_start   <= r_cur;
                r_target  <= r_new_duty;
                r_len     <= r_ftime;
                r_elapsed <= '0;
                r_fading  <= 1'b1;
            end
            if (i_cmd.tick_inc && (r_elapsed != '1)) begin
                r_elapsed <= r_elapsed + plf_pkg::TIME_BITS'(1);
            end
            if (i_cmd.tick_end) begin
                r_cur    <= r_target;
                r_fading <= 1'b0;
            end
            if (i_cmd.div_end) begin
                r_cur <= n_point;
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pct   <= n_pct;
            r_ftime <= i_fade_time_ms;
        end
        if (i_cmd.scale) begin
            r_scaled <= n_scaled;
        end
        if (i_cmd.recip) begin
            r_new_duty <= n_recip[plf_pkg::RECIP_SHIFT +: plf_pkg::DUTY_BITS];
        end
        if (i_cmd.mult) begin
            r_prod <= n_prod;
            r_span <= n_span;
            r_down <= n_down;
        end
        if (i_cmd.div_init) begin
            r_rem   <= n_num[plf_pkg::NUM_BITS-1:plf_pkg::DUTY_BITS];
            r_shift <= n_num[plf_pkg::DUTY_BITS-1:0];
        end else if (i_cmd.div_step) begin
            r_rem   <= n_rem;
            r_shift <= n_shift;
        end
        if (i_cmd.load_out) begin
            r_out_duty <= r_cur;
            r_out_fade <= r_fading;
        end
    end

    assign o_sts.fading   = r_fading;
    assign o_sts.fade_end = (r_elapsed >= r_len);
    assign o_duty_out     = 8'(r_out_duty);
    assign o_fade_active  = r_out_fade;

    // The operation bit is decoded by the controller; keep the latched copy for checking.
    logic r_op;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op <= i_operation;
        end
    end

`ifndef NO_ASSERTIONS
    // Set handling only follows a set transaction.
    a_set_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply_set |-> (r_op == plf_pkg::OP_SET))
        else $error("set applied for a tick transaction");

    // The line step never exceeds the span of the fade.
    a_q_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_end |-> (r_shift <= r_span))
        else $error("fade step exceeds the span");

    // Ending a fade lands exactly on the target.
    a_fade_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_end |=> (r_cur == r_target) && !r_fading)
        else $error("fade end did not reach the target");
`endif

endmodule

/* design/plf_ctrl.sv */
// Controller of the PWM fade controller: sequences set and tick transactions.
// Depends on plf_pkg for the command/status structs and counter width.
module plf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_operation,
    output logic                  o_valid,
    input  logic                  i_ready,
    input  plf_pkg::t_plf_status  i_sts,
    output plf_pkg::t_plf_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_RECIP,
        S_APPLY,
        S_TICK,
        S_CHECK,
        S_DIVINIT,
        S_DIV,
        S_FINISH,
        S_DONE
    } t_state;

    t_state                       r_state, n_state;
    logic [plf_pkg::CNT_BITS-1:0] r_count;
    logic                         r_out_valid;
    logic                         w_last;

    assign w_last  = (r_count == plf_pkg::CNT_BITS'(plf_pkg::DUTY_BITS - 1));
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_operation == plf_pkg::OP_SET) ? S_SCALE : S_TICK;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state = S_RECIP;
            end
            S_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply_set = 1'b1;
                n_state = S_DONE;
            end
            S_TICK: begin
                if (i_sts.fading) begin
                    o_cmd.tick_inc = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CHECK: begin
                if (i_sts.fade_end) begin
                    o_cmd.tick_end = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.mult = 1'b1;
                    n_state = S_DIVINIT;
                end
            end
            S_DIVINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (w_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.div_end = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, step counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.div_init) begin
                r_count <= '0;
            end else if (o_cmd.div_step) begin
                r_count <= r_count + plf_pkg::CNT_BITS'(1);
            end
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // An accepted transaction always leaves the idle state.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state != S_IDLE))
        else $error("accepted transaction not started");

    // Handing over a result raises valid and frees the input side.
    a_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_out_valid && r_state == S_IDLE))
        else $error("result hand-over failed");

    // The division counter stays within one step per quotient bit.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count <= plf_pkg::CNT_BITS'(plf_pkg::DUTY_BITS - 1)))
        else $error("division step counter overran");
`endif

endmodule

/* design/pwm_linear_fade_controller.sv */
// Top level of the PWM linear fade controller: joins the controller and the datapath.
// Depends on plf_pkg, plf_ctrl and plf_dpath.
//
//   Channel  Handshake              Payload
//   input    i_valid / o_ready      i_operation, i_target_percent, i_fade_time_ms
//   output   o_valid / i_ready      o_duty_out, o_fade_active
//
// A set transaction runs through clamp, scale multiply, reciprocal multiply and apply.
// A tick during a fade runs through the serial divider, which retires one quotient
// bit per cycle; a tick that ends a fade or comes outside a fade skips the divider.
// Reset is synchronous and active low; it clears the duty, the fade state and valid.
// A new transaction is taken while a result waits in the output register; the block
// only holds in its final step if that register is still full.
module pwm_linear_fade_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_target_percent,
    input  logic [15:0] i_fade_time_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_duty_out,
    output logic        o_fade_active
);

    plf_pkg::t_plf_cmd    w_cmd;
    plf_pkg::t_plf_status w_sts;

    // Sequencer.
    plf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Fade state and arithmetic.
    plf_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_operation      (i_operation),
        .i_target_percent (i_target_percent),
        .i_fade_time_ms   (i_fade_time_ms),
        .o_duty_out       (o_duty_out),
        .o_fade_active    (o_fade_active)
    );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the PWM linear fade controller.
// Depends on plf_pkg and pwm_linear_fade_controller; it reads no files.
`timescale 1ns / 100ps

module testbench;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int IDLE_PCT     = 37;
    // Transaction counts between which neither side idles.
    localparam int BURST_FROM   = 300;
    localparam int BURST_TO     = 550;

    typedef struct {
        logic        op;
        logic [7:0]  pct;
        logic [15:0] ftime;
    } t_fade_cmd;

    typedef struct {
        logic [7:0] duty;
        logic       active;
    } t_duty_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_operation = plf_pkg::OP_TICK;
    logic [7:0]  i_target_percent = '0;
    logic [15:0] i_fade_time_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_duty_out;
    logic        o_fade_active;

    t_fade_cmd    pending_cmds[$];
    t_duty_result expected_duty[$];

    int n_driven = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int cycle_count = 0;

    // Shadow state of the fader.
    logic [7:0]  cur_duty = '0;
    logic [7:0]  fade_start = '0;
    logic [7:0]  fade_target = '0;
    logic [15:0] fade_len = '0;
    logic [15:0] fade_elapsed = '0;
    logic        fading_now = 1'b0;

    pwm_linear_fade_controller i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_target_percent (i_target_percent),
        .i_fade_time_ms   (i_fade_time_ms),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_duty_out       (o_duty_out),
        .o_fade_active    (o_fade_active)
    );

    always #2 i_clk = ~i_clk;

    // Applies one transaction to the shadow state and returns the duty it reports.
    function automatic t_duty_result advance_fader(input t_fade_cmd cmd);
        int unsigned  pct_c;
        int unsigned  duty;
        int unsigned  span;
        int unsigned  move;
        t_duty_result res;
        if (cmd.op == plf_pkg::OP_SET) begin
            pct_c = (cmd.pct > plf_pkg::PERCENT_FULL) ? plf_pkg::PERCENT_FULL : cmd.pct;
            duty  = (pct_c * plf_pkg::DUTY_MAX) / plf_pkg::PERCENT_FULL;
            // A set to the present duty leaves everything alone, a running fade too.
            if (duty[7:0] != cur_duty) begin
                fade_start   = cur_duty;
                fade_target  = duty[7:0];
                fade_len     = cmd.ftime;
                fade_elapsed = '0;
                fading_now   = 1'b1;
            end
        end else if (fading_now) begin
            if (fade_elapsed != 16'hFFFF) begin
                fade_elapsed = fade_elapsed + 16'd1;
            end
            if (fade_elapsed >= fade_len) begin
                cur_duty   = fade_target;
                fading_now = 1'b0;
            end else if (fade_target >= fade_start) begin
                span     = fade_target - fade_start;
                move     = (span * fade_elapsed) / fade_len;
                cur_duty = fade_start + move[7:0];
            end else begin
                // Downward: floor of the line, so the step magnitude rounds up.
                span = fade_start - fade_target;
                move = (span * fade_elapsed + fade_len - 1) / fade_len;
                if (move > fade_start) begin
                    move = fade_start;
                end
                cur_duty = fade_start - move[7:0];
            end
        end
        res.duty   = cur_duty;
        res.active = fading_now;
        return res;
    endfunction

    function automatic void queue_cmd(input logic op, input int pct, input int ftime);
        t_fade_cmd cmd;
        cmd.op    = op;
        cmd.pct   = pct[7:0];
        cmd.ftime = ftime[15:0];
        pending_cmds.push_back(cmd);
    endfunction

    // Random percent: mostly in range, sometimes above full scale.
    function automatic int random_pct();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 100);
    endfunction

    // Driver: presents queued transactions at the falling edge.
    always @(negedge i_clk) begin : drive_proc
        logic      drive_valid;
        logic      idle;
        t_fade_cmd cmd;
        drive_valid = i_valid;
        if (i_rst_n) begin
            if (i_valid && n_accepted == n_driven) begin
                drive_valid = 1'b0;
            end
            if (!drive_valid && pending_cmds.size() > 0) begin
                idle = !(n_driven >= BURST_FROM && n_driven < BURST_TO) &&
                       ($urandom_range(0, 99) < IDLE_PCT);
                if (!idle) begin
                    cmd              = pending_cmds.pop_front();
                    i_operation      <= cmd.op;
                    i_target_percent <= cmd.pct;
                    i_fade_time_ms   <= cmd.ftime;
                    n_driven         <= n_driven + 1;
                    drive_valid      = 1'b1;
                end
            end
        end
        i_valid <= drive_valid;
    end

    // Receiver back-pressure, also at the falling edge.
    always @(negedge i_clk) begin
        if (n_results >= BURST_FROM && n_results < BURST_TO) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: predicts on each input transaction and checks each output transaction.
    always @(posedge i_clk) begin : monitor_proc
        t_fade_cmd    cmd;
        t_duty_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                cmd.op    = i_operation;
                cmd.pct   = i_target_percent;
                cmd.ftime = i_fade_time_ms;
                expected_duty.push_back(advance_fader(cmd));
                n_accepted <= n_accepted + 1;
            end
            if (o_valid && i_ready) begin
                n_results <= n_results + 1;
                if (expected_duty.size() == 0) begin
                    $display("%0t: unexpected result duty %0d active %0b", $realtime,
                             o_duty_out, o_fade_active);
                    n_errors = n_errors + 1;
                end else begin
                    want = expected_duty.pop_front();
                    if (o_duty_out !== want.duty) begin
                        $display("%0t: duty mismatch, expected %0d, actual %0d", $realtime,
                                 want.duty, o_duty_out);
                        n_errors = n_errors + 1;
                    end
                    if (o_fade_active !== want.active) begin
                        $display("%0t: fade flag mismatch, expected %0b, actual %0b",
                                 $realtime, want.active, o_fade_active);
                        n_errors = n_errors + 1;
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus_proc
        int base;
        int pct;
        int ftime;
        int n_ticks;

        // Directed: idle tick, no-op set, zero-length fade, clamp, downward fade,
        // a set to the present duty during a fade, and a restart during a fade.
        queue_cmd(plf_pkg::OP_TICK, 255, 65535);
        queue_cmd(plf_pkg::OP_SET, 0, 5);
        queue_cmd(plf_pkg::OP_SET, 100, 0);
        queue_cmd(plf_pkg::OP_TICK, 0, 0);
        queue_cmd(plf_pkg::OP_SET, 255, 3);
        queue_cmd(plf_pkg::OP_SET, 0, 3);
        queue_cmd(plf_pkg::OP_TICK, 0, 0);
        queue_cmd(plf_pkg::OP_TICK, 0, 0);
        queue_cmd(plf_pkg::OP_TICK, 0, 0);
        queue_cmd(plf_pkg::OP_SET, 50, 0);
        queue_cmd(plf_pkg::OP_TICK, 0, 0);
        queue_cmd(plf_pkg::OP_SET, 100, 1000);
        queue_cmd(plf_pkg::OP_TICK, 0, 0);
        queue_cmd(plf_pkg::OP_SET, 50, 7);
        queue_cmd(plf_pkg::OP_TICK, 0, 0);
        queue_cmd(plf_pkg::OP_SET, 1, 65535);
        queue_cmd(plf_pkg::OP_TICK, 0, 0);
        queue_cmd(plf_pkg::OP_TICK, 0, 0);
        queue_cmd(plf_pkg::OP_SET, 101, 16'hAAAA);
        queue_cmd(plf_pkg::OP_TICK, 0, 0);
        queue_cmd(plf_pkg::OP_SET, 99, 16'h5555);
        queue_cmd(plf_pkg::OP_TICK, 170, 16'h5555);
        queue_cmd(plf_pkg::OP_TICK, 255, 65535);

        // Random: mostly a set followed by a run of ticks, sometimes cut short;
        // the rest single transactions with random content.
        base = pending_cmds.size();
        while (pending_cmds.size() < base + RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 80) begin
                pct   = random_pct();
                ftime = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 30);
                queue_cmd(plf_pkg::OP_SET, pct, ftime);
                n_ticks = $urandom_range(0, ((ftime > 40) ? 40 : ftime) + 2);
                repeat (n_ticks) begin
                    queue_cmd(plf_pkg::OP_TICK, $urandom_range(0, 255),
                              $urandom_range(0, 65535));
                end
            end else begin
                queue_cmd(1'($urandom_range(0, 1)), random_pct(), $urandom_range(0, 65535));
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every transaction taken, every result back, then settle.
        while (pending_cmds.size() > 0 || n_accepted != n_driven || expected_duty.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_duty.size() > 0) begin
            n_errors = n_errors + 1;
        end
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
